// ----- rtl/ctd_pkg.sv -----
package ctd_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int CNT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int WORD_W  = 32;
    localparam int DEG_W   = 11;
    localparam int HASH_W  = 32;
    localparam int CMD_W   = 2;

    // stream packing, padded to whole bytes
    localparam int S_FIELDS_W = IDX_W + VAL_W + WORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DEG_W + HASH_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FOLD = 2'd2;

    localparam logic KIND_DEGREE = 1'b0;
    localparam logic KIND_HASH   = 1'b1;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'h0100_0193;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_TOT,
        ST_DRAW_CHK,
        ST_DRAW_MUL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FOLD_RD,
        ST_FOLD_LO,
        ST_FOLD_HI,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_TOTAL,
        RD_MID,
        RD_FOLD
    } rd_src_t;

    typedef struct packed {
        logic    take;        // input beat accepted
        logic    wr_en;       // table write from a load beat
        logic    rd_en;
        rd_src_t rd_src;
        logic    search_init;
        logic    mul_en;
        logic    target_en;
        logic    search_step;
        logic    fold_lo;
        logic    fold_hi;
        logic    res_load;
    } ctrl_t;

    typedef struct packed {
        logic n_zero;
        logic total_zero;
        logic search_done;
        logic fold_last;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/ctd_ctrl.sv -----
module ctd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic [ctd_pkg::CMD_W-1:0] s_cmd,
    output logic                  s_tready,
    input  ctd_pkg::stat_t        stat,
    output ctd_pkg::ctrl_t        ctrl
);
    import ctd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_DRAW: state_next = ST_DRAW_TOT;
                        CMD_FOLD: state_next = stat.n_zero ? ST_FINISH : ST_FOLD_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_TOT: state_next = stat.n_zero ? ST_FINISH : ST_DRAW_CHK;
            ST_DRAW_CHK: state_next = stat.total_zero ? ST_FINISH : ST_DRAW_MUL;
            ST_DRAW_MUL: state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = stat.search_done ? ST_FINISH : ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_FOLD_RD:  state_next = ST_FOLD_LO;
            ST_FOLD_LO:  state_next = ST_FOLD_HI;
            ST_FOLD_HI:  state_next = stat.fold_last ? ST_FINISH : ST_FOLD_RD;
            ST_FINISH:   state_next = stat.out_free ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl        = '0;
        ctrl.rd_src = RD_TOTAL;
        case (state_reg)
            ST_IDLE: begin
                ctrl.take  = accept;
                ctrl.wr_en = accept && (s_cmd == CMD_LOAD);
            end
            ST_DRAW_TOT: begin
                // lo starts at zero, so an empty table answers degree one
                ctrl.rd_en       = 1'b1;
                ctrl.rd_src      = RD_TOTAL;
                ctrl.search_init = 1'b1;
            end
            ST_DRAW_CHK: ctrl.mul_en = !stat.total_zero;
            ST_DRAW_MUL: ctrl.target_en = 1'b1;
            ST_SRCH_RD: begin
                ctrl.rd_en  = !stat.search_done;
                ctrl.rd_src = RD_MID;
            end
            ST_SRCH_CMP: ctrl.search_step = 1'b1;
            ST_FOLD_RD: begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_src = RD_FOLD;
            end
            ST_FOLD_LO:  ctrl.fold_lo = 1'b1;
            ST_FOLD_HI:  ctrl.fold_hi = 1'b1;
            ST_FINISH:   ctrl.res_load = stat.out_free;
            default:     ctrl = '0;
        endcase
    end

endmodule

// ----- rtl/ctd_datapath.sv -----
module ctd_datapath #(
    parameter int TABLE_DEPTH = ctd_pkg::DEF_TABLE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctd_pkg::ctrl_t             ctrl,
    output ctd_pkg::stat_t             stat,
    input  logic                       cfg_wr_en,
    input  logic [ctd_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic [ctd_pkg::CMD_W-1:0]  in_cmd,
    input  logic [ctd_pkg::IDX_W-1:0]  in_entry_index,
    input  logic [ctd_pkg::VAL_W-1:0]  in_entry_value,
    input  logic [ctd_pkg::WORD_W-1:0] in_word,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic                       out_result_kind,
    output logic [ctd_pkg::DEG_W-1:0]  out_degree,
    output logic [ctd_pkg::HASH_W-1:0] out_hash
);
    import ctd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = (AW > CNT_W) ? AW : CNT_W;

    logic [VAL_W-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_m1;
    logic [WORD_W-1:0] word_reg;
    logic              kind_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    logic [VAL_W-1:0]  prod_hi_reg;
    logic [VAL_W-1:0]  prod_lo_reg;
    logic [VAL_W-1:0]  target_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  fold_idx_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] fold_lo_next;
    logic [HASH_W-1:0] fold_hi_next;

    logic [CNT_W-1:0]  rd_idx;
    logic [XW-1:0]     rd_idx_x;
    logic [XW-1:0]     wr_idx_x;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_in_range;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic              out_kind_reg;
    logic [DEG_W-1:0]  out_degree_reg;
    logic [HASH_W-1:0] out_hash_reg;

    // clamp the entry count to the table depth when it is written
    always_comb begin
        if (32'(cfg_wr_data) > TABLE_DEPTH) begin
            count_next = CNT_W'(TABLE_DEPTH);
        end else begin
            count_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= count_next;
        end
    end

    assign count_m1 = count_reg - 1'b1;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        case (ctrl.rd_src)
            RD_TOTAL: rd_idx = count_m1;
            RD_MID:   rd_idx = mid;
            RD_FOLD:  rd_idx = fold_idx_reg;
            default:  rd_idx = count_m1;
        endcase
    end

    assign rd_idx_x    = XW'(rd_idx);
    assign rd_addr     = rd_idx_x[AW-1:0];
    assign wr_idx_x    = XW'(in_entry_index);
    assign wr_addr     = wr_idx_x[AW-1:0];
    assign wr_in_range = (32'(in_entry_index) < TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && wr_in_range) begin
            mem[wr_addr] <= in_entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign fold_lo_next = HASH_W'((hash_reg ^ rd_data_reg[WORD_W-1:0]) * HASH_MULT);
    assign fold_hi_next = HASH_W'((hash_reg ^ rd_data_reg[VAL_W-1:WORD_W]) * HASH_MULT);

    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            word_reg     <= in_word;
            kind_reg     <= (in_cmd == CMD_FOLD) ? KIND_HASH : KIND_DEGREE;
            hash_reg     <= in_word;
            fold_idx_reg <= '0;
        end
        if (ctrl.search_init) begin
            lo_reg <= '0;
            hi_reg <= count_m1;
        end
        if (ctrl.mul_en) begin
            prod_hi_reg <= 64'(rd_data_reg[VAL_W-1:WORD_W]) * 64'(word_reg);
            prod_lo_reg <= 64'(rd_data_reg[WORD_W-1:0]) * 64'(word_reg);
        end
        if (ctrl.target_en) begin
            target_reg <= prod_hi_reg + {32'b0, prod_lo_reg[VAL_W-1:WORD_W]};
        end
        if (ctrl.rd_en && (ctrl.rd_src == RD_MID)) begin
            mid_reg <= mid;
        end
        if (ctrl.search_step) begin
            if (rd_data_reg > target_reg) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg + 1'b1;
            end
        end
        if (ctrl.fold_lo) begin
            hash_reg <= fold_lo_next;
        end
        if (ctrl.fold_hi) begin
            hash_reg     <= fold_hi_next;
            fold_idx_reg <= fold_idx_reg + 1'b1;
        end
    end

    // output register: holds a finished beat while the next item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.res_load) begin
            out_kind_reg   <= kind_reg;
            out_degree_reg <= (kind_reg == KIND_HASH) ? '0 : DEG_W'(lo_reg + 1'b1);
            out_hash_reg   <= (kind_reg == KIND_HASH) ? hash_reg : '0;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign out_result_kind = out_kind_reg;
    assign out_degree      = out_degree_reg;
    assign out_hash        = out_hash_reg;

    assign stat.n_zero      = (count_reg == '0);
    assign stat.total_zero  = (rd_data_reg == '0);
    assign stat.search_done = !(lo_reg < hi_reg);
    assign stat.fold_last   = (fold_idx_reg == count_m1);
    assign stat.out_free    = !m_valid_reg || m_tready;

endmodule

// ----- rtl/cumulative_table_degree_draw.sv -----
// Inverse-CDF degree draw over a table of 64-bit cumulative weights.
//
// Input stream (s_*): one beat per command, selected by s_tuser. A load beat
// writes one table entry; loads can stream back to back. A draw beat scales
// s_tdata's word into the total (the last entry in use) and binary-searches
// the table; a fold beat hashes every entry in use. Output stream (m_*): one
// beat per draw or fold, none for a load. The user must set the entry count
// through cfg_wr_en/cfg_wr_data while the block idles; it is not enforced.
//
// From accept to the result in the output register, a draw reads the total,
// scales the word into it and then probes the table once per search step,
// each probe a read and a compare through the single registered read port of
// the table. A fold reads each entry in use and hashes its low and high words.
// One item is worked on at a time; s_tready is high only when idle.
//
// Reset clears the entry count and the control state; table contents are
// undefined until loaded. When m_tready is low a finished beat waits in the
// output register and a new command is still accepted; the next result waits
// until that register drains.
module cumulative_table_degree_draw #(
    parameter int TABLE_DEPTH = ctd_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ctd_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] entry_index, [73:10] entry_value, [105:74] word, rest zero
    input  logic [ctd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [ctd_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] degree, [42:11] hash, rest zero
    output logic [ctd_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] result_kind
    output logic                           m_tuser
);
    import ctd_pkg::*;

    ctrl_t             ctrl;
    stat_t             stat;
    logic [DEG_W-1:0]  out_degree;
    logic [HASH_W-1:0] out_hash;

    ctd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ctd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_cmd          (s_tuser),
        .in_entry_index  (s_tdata[IDX_W-1:0]),
        .in_entry_value  (s_tdata[IDX_W+VAL_W-1:IDX_W]),
        .in_word         (s_tdata[S_FIELDS_W-1:IDX_W+VAL_W]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_result_kind (m_tuser),
        .out_degree      (out_degree),
        .out_hash        (out_hash)
    );

    assign m_tdata = M_TDATA_W'({out_hash, out_degree});

endmodule

// ----- test/ctd_answer_checker.sv -----
module ctd_answer_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ctd_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ctd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ctd_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ctd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tuser,
    output int                             mismatches,
    output int                             answers_owed,
    output int                             answers_seen
);
    import ctd_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [DEG_W-1:0]  degree;
        logic [HASH_W-1:0] hash;
    } answer_t;

    answer_t          answer_queue[$];
    logic [VAL_W-1:0] weight_table [DEF_TABLE_DEPTH];
    logic [CNT_W-1:0] entry_count_q;

    function automatic int entries_used();
        int n;
        n = int'(entry_count_q);
        if (n > DEF_TABLE_DEPTH) begin
            n = DEF_TABLE_DEPTH;
        end
        return n;
    endfunction

    function automatic logic [DEG_W-1:0] predict_degree(input logic [WORD_W-1:0] w);
        int n;
        int lo;
        int hi;
        int mid;
        logic [VAL_W-1:0] total;
        logic [VAL_W-1:0] target;
        logic [VAL_W-1:0] upper;
        logic [VAL_W-1:0] lower;
        n = entries_used();
        if (n == 0) begin
            return DEG_W'(1);
        end
        total = weight_table[n-1];
        if (total == '0) begin
            return DEG_W'(1);
        end
        // split multiply, wraps at 64 bits
        upper  = {32'd0, total[63:32]} * {32'd0, w};
        lower  = ({32'd0, total[31:0]} * {32'd0, w}) >> 32;
        target = upper + lower;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (weight_table[mid] > target) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return DEG_W'(lo + 1);
    endfunction

    function automatic logic [HASH_W-1:0] predict_hash(input logic [WORD_W-1:0] seed);
        int n;
        logic [HASH_W-1:0] h;
        n = entries_used();
        h = seed;
        for (int i = 0; i < n; i++) begin
            h = (h ^ weight_table[i][31:0]) * HASH_MULT;
            h = (h ^ weight_table[i][63:32]) * HASH_MULT;
        end
        return h;
    endfunction

    task automatic queue_answer(input answer_t a);
        answer_queue = {answer_queue, a};
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
        mismatches++;
        $display("MISMATCH %s: got %0h, expected %0h (answer %0d)",
                 what, got_v, want_v, answers_seen);
    endtask

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic [WORD_W-1:0] w;
        if (!aresetn) begin
            entry_count_q = '0;
            answer_queue.delete();
            mismatches   = 0;
            answers_seen = 0;
        end else begin
            // retire the output beat first: it never belongs to this edge's input
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.degree = m_tdata[DEG_W-1:0];
                got.hash   = m_tdata[DEG_W +: HASH_W];
                answers_seen++;
                if (answer_queue.size() == 0) begin
                    flag_mismatch("beat with no answer due", 64'(got), 64'd0);
                end else begin
                    want = answer_queue.pop_front();
                    if (got.kind != want.kind) begin
                        flag_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
                    end
                    if (got.degree != want.degree) begin
                        flag_mismatch("degree", 64'(got.degree), 64'(want.degree));
                    end
                    if (got.hash != want.hash) begin
                        flag_mismatch("hash", 64'(got.hash), 64'(want.hash));
                    end
                end
                if (m_tdata[M_TDATA_W-1:M_FIELDS_W] != '0) begin
                    flag_mismatch("tdata padding", 64'(m_tdata[M_TDATA_W-1:M_FIELDS_W]),
                                  64'd0);
                end
            end
            if (cfg_wr_en) begin
                entry_count_q = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                idx = s_tdata[IDX_W-1:0];
                val = s_tdata[IDX_W +: VAL_W];
                w   = s_tdata[IDX_W+VAL_W +: WORD_W];
                case (s_tuser)
                    CMD_LOAD: begin
                        if (idx < DEF_TABLE_DEPTH) begin
                            weight_table[idx] = val;
                        end
                    end
                    CMD_DRAW: begin
                        queue_answer({KIND_DEGREE, predict_degree(w), {HASH_W{1'b0}}});
                    end
                    CMD_FOLD: begin
                        queue_answer({KIND_HASH, {DEG_W{1'b0}}, predict_hash(w)});
                    end
                    default: begin
                    end
                endcase
            end
        end
        answers_owed = answer_queue.size();
    end

endmodule

// ----- test/cumulative_table_degree_draw_test.sv -----
module cumulative_table_degree_draw_test;
    import ctd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DIRECTED_ITEMS = 19;
    localparam int MIXED_ITEMS    = 150;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {FILL_RISING, FILL_ZERO, FILL_NOISE, FILL_FULL_SCALE, FILL_SMALL} fill_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CNT_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    int mismatches;
    int answers_owed;
    int answers_seen;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    int  items_sent     = 0;
    int  n_loads        = 0;
    int  n_draws        = 0;
    int  n_folds        = 0;
    int  n_ignored      = 0;
    bit  loaded [DEF_TABLE_DEPTH];

    cumulative_table_degree_draw u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    ctd_answer_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .answers_owed (answers_owed),
        .answers_seen (answers_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no beat moved in %0d cycles", quiet);
        $display("== FAIL ==");
        $finish;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default:   begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-S_FIELDS_W){1'b0}}, w, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        case (cmd)
            CMD_LOAD: begin n_loads++; loaded[idx] = 1'b1; end
            CMD_DRAW: n_draws++;
            CMD_FOLD: n_folds++;
            default:  n_ignored++;
        endcase
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        send_beat(CMD_LOAD, idx, val, $urandom);
    endtask

    task automatic draw(input logic [WORD_W-1:0] w);
        send_beat(CMD_DRAW, IDX_W'($urandom), {$urandom, $urandom}, w);
    endtask

    task automatic fold(input logic [WORD_W-1:0] seed);
        send_beat(CMD_FOLD, IDX_W'($urandom), {$urandom, $urandom}, seed);
    endtask

    task automatic junk_beat();
        send_beat(CMD_UNUSED, IDX_W'($urandom), {$urandom, $urandom}, $urandom);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    // hold the sender until every answer is back, then let a trailing load land
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic bit table_ready(input int n);
        for (int i = 0; i < n && i < DEF_TABLE_DEPTH; i++) begin
            if (!loaded[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic fill_table(input int n, input fill_t pattern);
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] v;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            case (pattern)
                FILL_RISING: begin
                    if ($urandom_range(0, 3) != 0) begin
                        acc = acc + {30'd0, 2'($urandom_range(0, 3)), $urandom};
                    end
                    v = acc;
                end
                FILL_ZERO:  v = '0;
                FILL_NOISE: v = {$urandom, $urandom};
                FILL_FULL_SCALE: begin
                    acc = (i == n - 1) ? 64'hFFFF_FFFF_FFFF_FFFF
                                       : acc + 64'hFFFF_FFFF_FFFF_FFFF / 64'(n);
                    v = acc;
                end
                default: begin
                    acc = acc + 64'($urandom_range(0, 1000));
                    v = acc;
                end
            endcase
            load_entry(IDX_W'(i), v);
        end
    endtask

    initial begin
        int p;
        int n;
        int k;
        int r;
        int top_idx;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_LOAD;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, ignored command, zero total, extremes
        set_idling(IDLE_NONE);
        draw('0);
        fold('1);
        junk_beat();
        write_count(11'd1);
        load_entry('0, '0);
        draw('1);
        load_entry('0, '1);
        draw('1);
        draw('0);
        fold('0);
        write_count(11'd4);
        for (int i = 0; i < 4; i++) begin
            load_entry(IDX_W'(i), 64'(i + 1) << 32);
        end
        load_entry('1, '1);
        draw('0);
        draw(32'h4000_0000);
        draw(32'h8000_0000);
        draw('1);
        fold(32'h811C_9DC5);

        // hold the receiver off long enough that the block backs up its input
        drain();
        hold_left = 300;
        repeat (6) draw($urandom);
        drain();

        // mixed phases: a fresh count, a refill if needed, then draws and noise
        p = 0;
        while (items_sent < DIRECTED_ITEMS + MIXED_ITEMS || p < 4) begin
            set_idling(idle_mode_t'(p % 4));
            r = $urandom_range(0, 99);
            if (r < 5) begin
                n = 0;
            end else if (r < 70) begin
                n = $urandom_range(1, 8);
            end else if (r < 95) begin
                n = $urandom_range(9, 40);
            end else begin
                n = $urandom_range(41, 100);
            end
            write_count(CNT_W'(n));
            if (!table_ready(n) || $urandom_range(0, 2) == 0) begin
                fill_table(n, fill_t'($urandom_range(0, 4)));
            end
            top_idx = (n + 8 > DEF_TABLE_DEPTH - 1) ? DEF_TABLE_DEPTH - 1 : n + 8;
            k = $urandom_range(8, 24);
            repeat (k) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    draw(pick_word());
                end else if (r < 75 && n <= 40) begin
                    fold(pick_word());
                end else if (r < 88) begin
                    load_entry(IDX_W'($urandom_range(0, top_idx)), {$urandom, $urandom});
                end else if (r < 94) begin
                    junk_beat();
                end else begin
                    load_entry(IDX_W'($urandom), {$urandom, $urandom});
                end
            end
            p++;
        end

        // full table, then counts at, above and just below the depth
        write_count(11'd0);
        set_idling(IDLE_NONE);
        fill_table(DEF_TABLE_DEPTH, FILL_RISING);
        set_idling(IDLE_BOTH);
        write_count(11'd1024);
        repeat (8) draw(pick_word());
        fold($urandom);
        write_count(11'd2047);
        repeat (8) draw(pick_word());
        fold($urandom);
        set_idling(IDLE_RECV);
        write_count(CNT_W'($urandom_range(1025, 2046)));
        repeat (4) draw(pick_word());
        write_count(11'd1023);
        repeat (4) draw(pick_word());

        drain();
        repeat (30) @(posedge aclk);
        $display("Sent %0d beats: %0d loads, %0d draws, %0d folds, %0d ignored commands",
                 items_sent, n_loads, n_draws, n_folds, n_ignored);
        $display("Checked %0d answers over entry counts 0 to 2047, with %0d mismatches",
                 answers_seen, mismatches);
        if (mismatches == 0 && answers_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ctd_pkg.sv
rtl/ctd_ctrl.sv
rtl/ctd_datapath.sv
rtl/cumulative_table_degree_draw.sv
test/ctd_answer_checker.sv
test/cumulative_table_degree_draw_test.sv
